// ----- design/nsfe_pkg.sv -----
// Shared types, character codes and event codes of the sentence field extractor.
package nsfe_pkg;

   // Sentence framing characters.
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [3:0] HEX_TEN    = 4'd10;

   // Fixed limits on the tag and the slots.
   localparam logic [3:0] MAX_TAG   = 4'd8;
   localparam logic [2:0] NUM_SLOTS = 3'd4;
   localparam int         SLOT_BITS = 4;

   // Depth of the command queue between the front and the back.
   localparam int Q_DEPTH = 2;

   // Result event codes.
   localparam logic [2:0] EV_NONE  = 3'd0;
   localparam logic [2:0] EV_START = 3'd1;
   localparam logic [2:0] EV_BYTE  = 3'd2;
   localparam logic [2:0] EV_MARK  = 3'd3;
   localparam logic [2:0] EV_VALID = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_TAG_CHARS  = 2'd0;
   localparam logic [1:0] CSR_TAG_LENGTH = 2'd1;
   localparam logic [1:0] CSR_SLOT_COUNT = 2'd2;
   localparam logic [1:0] CSR_SLOT_FIELDS = 2'd3;

   // Configuration as seen by the parser.
   typedef struct packed {
      logic [63:0] tag_chars;
      logic [3:0]  tag_length;
      logic [2:0]  slot_count;
      logic [31:0] slot_field_numbers;
   } cfg_type;

   // One queued command: the final event kind and the slots it goes to.
   typedef struct packed {
      logic [2:0]           kind;
      logic [SLOT_BITS-1:0] mask;
   } cmd_type;

endpackage

// ----- design/nmea_sentence_field_extractor.sv -----
// Top level: configuration registers, parser, command queue, field store, sequencer.
// Path: a start or sentence-valid event passes through the command queue, the sequencer
// state and the result register; a field dump begins the same way after the closing ',' or '*'.
// Throughput: one character per cycle when it causes no field dump and the command queue
// is not full. A dump reads each stored byte through the field store's registered read port,
// and no character is taken until the dump's final mark is loaded.
// Reset: synchronous, active high; clears parser, queue, sequencer and registers.
module nmea_sentence_field_extractor
   import nsfe_pkg::*;
#(
   parameter int FIELD_LEN = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Character input.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_char
   // Result output.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] data_byte, [11:8] slot_mask, [15:12] zero
   output logic [2:0]  rsp_tuser,   // [2:0] event_kind
   output logic        rsp_tlast,   // last_of_run
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int LEN_W = $clog2(FIELD_LEN);
   localparam int AW    = (FIELD_LEN > 2) ? $clog2(FIELD_LEN - 1) : 1;
   localparam int QW    = $bits(cmd_type) + LEN_W;

   cfg_type cfg_ff, cfg_in;

   logic             cmd_push;
   cmd_type          cmd;
   logic [LEN_W-1:0] cmd_len;
   logic             q_full;
   logic             q_empty;
   logic             q_pop;
   logic [QW-1:0]    q_rd;
   cmd_type          q_cmd;
   logic [LEN_W-1:0] q_len;
   logic             store_en;
   logic [AW-1:0]    store_addr;
   logic [7:0]       store_data;
   logic [AW-1:0]    rd_addr;
   logic [7:0]       rd_data;
   logic             dump_done;
   logic             dump_pending;

   // Configuration register writes.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TAG_CHARS:   cfg_in.tag_chars          = csr_data;
            CSR_TAG_LENGTH:  cfg_in.tag_length         = csr_data[3:0];
            CSR_SLOT_COUNT:  cfg_in.slot_count         = csr_data[2:0];
            CSR_SLOT_FIELDS: cfg_in.slot_field_numbers = csr_data[31:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Parser front.
   nsfe_front #(.FIELD_LEN(FIELD_LEN)) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .q_full       (q_full),
      .dump_done    (dump_done),
      .cmd_push     (cmd_push),
      .cmd          (cmd),
      .cmd_len      (cmd_len),
      .store_en     (store_en),
      .store_addr   (store_addr),
      .store_data   (store_data),
      .dump_pending (dump_pending)
   );

   // Command queue.
   nsfe_queue #(.WIDTH(QW)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data ({cmd, cmd_len}),
      .pop     (q_pop),
      .rd_data (q_rd),
      .full    (q_full),
      .empty   (q_empty)
   );

   assign q_cmd = q_rd[QW-1:LEN_W];
   assign q_len = q_rd[LEN_W-1:0];

   // Field byte store.
   nsfe_ram #(.WIDTH(8), .DEPTH(FIELD_LEN - 1)) u_store (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (store_addr),
      .wr_data (store_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Result sequencer.
   nsfe_back #(.FIELD_LEN(FIELD_LEN)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_cmd      (q_cmd),
      .q_len      (q_len),
      .q_pop      (q_pop),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .dump_done  (dump_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // No character transfer while a field dump still reads the store.
   a_no_accept_in_dump: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !dump_pending)
      else $error("character taken during a field dump");

   // The queue is never written when full.
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !q_full)
      else $error("command queue overflow");

   // Only field bytes go out without the last mark.
   a_last_vs_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == EV_BYTE) != rsp_tlast))
      else $error("last mark does not match event kind");

   // A field byte always goes to at least one slot.
   a_byte_has_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == EV_BYTE) |-> (rsp_tdata[11:8] != 4'd0))
      else $error("field byte with empty slot mask");

endmodule

// ----- design/nsfe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module nsfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/nsfe_queue.sv -----
// Short command queue that decouples the parser from the result sequencer.
module nsfe_queue
   import nsfe_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);

   localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CW = $clog2(Q_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [Q_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full    = (count_ff == CW'(Q_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- design/nsfe_front.sv -----
// Character parser: tag match, field split, checksum check and command issue.
module nsfe_front
   import nsfe_pkg::*;
#(
   parameter int FIELD_LEN = 16,
   localparam int LEN_W = $clog2(FIELD_LEN),
   localparam int AW = (FIELD_LEN > 2) ? $clog2(FIELD_LEN - 1) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             q_full,
   input  logic             dump_done,
   output logic             cmd_push,
   output cmd_type          cmd,
   output logic [LEN_W-1:0] cmd_len,
   output logic             store_en,
   output logic [AW-1:0]    store_addr,
   output logic [7:0]       store_data,
   output logic             dump_pending
);

   localparam logic [LEN_W-1:0] STORE_MAX = LEN_W'(FIELD_LEN - 1);

   // Parser state.
   logic             in_sentence_ff, in_sentence_in;
   logic [3:0]       tag_pos_ff, tag_pos_in;
   logic             in_checksum_ff, in_checksum_in;
   logic [7:0]       xor_ff, xor_in;
   logic             have_high_ff, have_high_in;
   logic [3:0]       high_digit_ff, high_digit_in;
   logic [7:0]       field_num_ff, field_num_in;
   logic [LEN_W-1:0] field_len_ff, field_len_in;
   logic             dump_pending_ff, dump_pending_in;

   logic                 accept;
   logic [7:0]           c;
   logic [3:0]           tlen;
   logic [2:0]           slots_use;
   logic [7:0]           want;
   logic [SLOT_BITS-1:0] field_mask;
   logic [SLOT_BITS-1:0] start_mask;
   logic                 is_hex;
   logic [3:0]           hex_val;
   logic                 do_clear;
   logic                 do_start;

   assign req_tready   = !q_full && !dump_pending_ff;
   assign accept       = req_tvalid && req_tready;
   assign c            = req_tdata;
   assign dump_pending = dump_pending_ff;

   // Limits on the tag length and on the slots in use.
   assign tlen      = (cfg.tag_length > MAX_TAG) ? MAX_TAG : cfg.tag_length;
   assign slots_use = (cfg.slot_count > NUM_SLOTS) ? NUM_SLOTS : cfg.slot_count;
   assign want      = cfg.tag_chars[{tag_pos_ff[2:0], 3'b000} +: 8];

   // Slots that take the current field, and the slots in use.
   always_comb begin
      for (int i = 0; i < SLOT_BITS; i++) begin
         start_mask[i] = (3'(i) < slots_use);
         field_mask[i] = start_mask[i] &&
                         (cfg.slot_field_numbers[8*i +: 8] == field_num_ff);
      end
   end

   // Uppercase hex digit decode.
   always_comb begin
      is_hex  = 1'b0;
      hex_val = '0;
      if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
         is_hex  = 1'b1;
         hex_val = 4'(c - CH_UPPER_A) + HEX_TEN;
      end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
         is_hex  = 1'b1;
         hex_val = 4'(c - CH_DIGIT_0);
      end
   end

   // Next parser state and the command that a character issues.
   always_comb begin
      in_sentence_in  = in_sentence_ff;
      tag_pos_in      = tag_pos_ff;
      in_checksum_in  = in_checksum_ff;
      xor_in          = xor_ff;
      have_high_in    = have_high_ff;
      high_digit_in   = high_digit_ff;
      field_num_in    = field_num_ff;
      field_len_in    = field_len_ff;
      dump_pending_in = dump_pending_ff && !dump_done;
      cmd_push        = 1'b0;
      cmd.kind        = EV_NONE;
      cmd.mask        = '0;
      cmd_len         = field_len_ff;
      store_en        = 1'b0;
      do_clear        = 1'b0;
      do_start        = 1'b0;

      if (accept) begin
         if (!in_sentence_ff) begin
            do_start = (c == CH_DOLLAR);
         end else if (tag_pos_ff < tlen) begin
            // Tag characters must match in order.
            if (c == want) begin
               tag_pos_in = tag_pos_ff + 4'd1;
               xor_in     = xor_ff ^ c;
            end else begin
               do_clear = 1'b1;
            end
         end else if (!in_checksum_ff) begin
            if (c == CH_DOLLAR) begin
               do_clear = 1'b1;
            end else if (c == CH_COMMA || c == CH_STAR) begin
               // End of a field: hand the stored bytes to the back end when a slot takes the field.
               if (field_mask != '0) begin
                  cmd_push        = 1'b1;
                  cmd.kind        = EV_MARK;
                  cmd.mask        = field_mask;
                  dump_pending_in = 1'b1;
               end
               if (c == CH_STAR) begin
                  in_checksum_in = 1'b1;
                  have_high_in   = 1'b0;
               end else begin
                  if (field_num_ff != 8'hFF) begin
                     field_num_in = field_num_ff + 8'd1;
                  end
                  field_len_in = '0;
                  xor_in       = xor_ff ^ c;
               end
            end else begin
               // Data character: store it while room remains.
               if (field_len_ff < STORE_MAX) begin
                  store_en     = 1'b1;
                  field_len_in = field_len_ff + LEN_W'(1);
               end
               xor_in = xor_ff ^ c;
            end
         end else begin
            // Two hex digits of checksum after the star.
            if (!is_hex) begin
               do_clear = 1'b1;
            end else if (!have_high_ff) begin
               high_digit_in = hex_val;
               have_high_in  = 1'b1;
            end else if ({high_digit_ff, hex_val} == xor_ff) begin
               do_clear = 1'b1;
               cmd_push = 1'b1;
               cmd.kind = EV_VALID;
               cmd.mask = '0;
            end else begin
               do_clear = 1'b1;
            end
         end

         // Return to idle; a dollar sign opens a new sentence at once.
         if (do_clear) begin
            in_sentence_in = 1'b0;
            tag_pos_in     = '0;
            in_checksum_in = 1'b0;
            xor_in         = '0;
            have_high_in   = 1'b0;
            high_digit_in  = '0;
            field_num_in   = '0;
            field_len_in   = '0;
            if (c == CH_DOLLAR && cmd.kind != EV_VALID) begin
               do_start = 1'b1;
            end
         end

         if (do_start) begin
            in_sentence_in = 1'b1;
            cmd_push       = 1'b1;
            cmd.kind       = EV_START;
            cmd.mask       = start_mask;
         end
      end
   end

   assign store_addr = field_len_ff[AW-1:0];
   assign store_data = c;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sentence_ff  <= 1'b0;
         tag_pos_ff      <= '0;
         in_checksum_ff  <= 1'b0;
         xor_ff          <= '0;
         have_high_ff    <= 1'b0;
         high_digit_ff   <= '0;
         field_num_ff    <= '0;
         field_len_ff    <= '0;
         dump_pending_ff <= 1'b0;
      end else begin
         in_sentence_ff  <= in_sentence_in;
         tag_pos_ff      <= tag_pos_in;
         in_checksum_ff  <= in_checksum_in;
         xor_ff          <= xor_in;
         have_high_ff    <= have_high_in;
         high_digit_ff   <= high_digit_in;
         field_num_ff    <= field_num_in;
         field_len_ff    <= field_len_in;
         dump_pending_ff <= dump_pending_in;
      end
   end

endmodule

// ----- design/nsfe_back.sv -----
// Result sequencer: reads stored field bytes and drives the result register.
module nsfe_back
   import nsfe_pkg::*;
#(
   parameter int FIELD_LEN = 16,
   localparam int LEN_W = $clog2(FIELD_LEN),
   localparam int AW = (FIELD_LEN > 2) ? $clog2(FIELD_LEN - 1) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  cmd_type              q_cmd,
   input  logic [LEN_W-1:0]     q_len,
   output logic                 q_pop,
   output logic [AW-1:0]        rd_addr,
   input  logic [7:0]           rd_data,
   output logic                 dump_done,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,
   output logic [2:0]           rsp_tuser,
   output logic                 rsp_tlast
);

   // Sequencer states.
   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_READ = 2'd1;
   localparam logic [1:0] B_BYTE = 2'd2;
   localparam logic [1:0] B_LAST = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [2:0]           kind_ff, kind_in;
   logic [SLOT_BITS-1:0] mask_ff, mask_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [LEN_W-1:0]     idx_ff, idx_in;

   // Result register.
   logic                 out_valid_ff, out_valid_in;
   logic [2:0]           out_kind_ff, out_kind_in;
   logic [7:0]           out_data_ff, out_data_in;
   logic [SLOT_BITS-1:0] out_mask_ff, out_mask_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_free;

   assign out_free = !out_valid_ff || rsp_tready;
   assign q_pop    = (state_ff == B_IDLE) && !q_empty;
   assign rd_addr  = idx_ff[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      mask_in      = mask_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_kind_in  = out_kind_ff;
      out_data_in  = out_data_ff;
      out_mask_in  = out_mask_ff;
      out_last_in  = out_last_ff;
      dump_done    = 1'b0;

      case (state_ff)
         B_IDLE: begin
            // Take the next command from the queue.
            if (!q_empty) begin
               kind_in = q_cmd.kind;
               mask_in = q_cmd.mask;
               len_in  = q_len;
               idx_in  = '0;
               if (q_cmd.kind == EV_MARK && q_len != '0) begin
                  state_in = B_READ;
               end else begin
                  state_in = B_LAST;
               end
            end
         end
         B_READ: begin
            // The store's read data is registered; wait here for it.
            state_in = B_BYTE;
         end
         B_BYTE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = EV_BYTE;
               out_data_in  = rd_data;
               out_mask_in  = mask_ff;
               out_last_in  = 1'b0;
               idx_in       = idx_ff + LEN_W'(1);
               state_in     = (idx_ff + LEN_W'(1) == len_ff) ? B_LAST : B_READ;
            end
         end
         B_LAST: begin
            // Final event of the run carries the last mark.
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = kind_ff;
               out_data_in  = '0;
               out_mask_in  = mask_ff;
               out_last_in  = 1'b1;
               dump_done    = (kind_ff == EV_MARK);
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      mask_ff     <= mask_in;
      len_ff      <= len_in;
      idx_ff      <= idx_in;
      out_kind_ff <= out_kind_in;
      out_data_ff <= out_data_in;
      out_mask_ff <= out_mask_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {4'b0000, out_mask_ff, out_data_ff};
   assign rsp_tlast  = out_last_ff;

endmodule
